FILE: hw/rtl/desf_pkg.sv
// desf_pkg: shared types and constants for the double exponential smoothing forecaster
// holds the controller/datapath command and status structs and the register indexes
// no dependencies
`default_nettype none

package desf_pkg;

   // fixed field widths
   localparam int LEVEL_W    = 32;
   localparam int ALPHA_W    = 17;
   localparam int BETA_W     = 16;
   localparam int GAIN_W     = 24;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // shared multiplier: signed 25 x 34 giving 59 bits
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 34;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // unity in Q1.16
   localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ALPHA         = 2'd0,
      CSR_BETA          = 2'd1,
      CSR_TREND_GAIN    = 2'd2,
      CSR_INITIAL_LEVEL = 2'd3
   } csr_index_type;

   // operand pair fed to the shared multiplier
   typedef enum logic [2:0] {
      MUL_HOLD,
      MUL_ALPHA_PREV,
      MUL_NALPHA_LEVEL,
      MUL_BETA_S1,
      MUL_NBETA_S2,
      MUL_ALPHA_SAMPLE,
      MUL_NALPHA_S1,
      MUL_GAIN_DIFF
   } mul_op_type;

   // accumulator load
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD_SHIFT,
      ACC_LOAD,
      ACC_LOAD_TREND
   } acc_op_type;

   // destination of the accumulator plus product
   typedef enum logic [2:0] {
      WB_NONE,
      WB_FIRST,
      WB_SECOND,
      WB_SINGLE,
      WB_RESULT
   } wb_op_type;

   typedef struct packed {
      logic       capture;
      mul_op_type mul_op;
      acc_op_type acc_op;
      wb_op_type  wb_op;
   } dp_cmd_type;

   typedef struct packed {
      logic start;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/desf_dp.sv
// desf_dp: datapath of the forecaster, one shared multiplier, accumulator and level registers
// also holds the configuration registers and the result output register
// depends on desf_pkg
`default_nettype none

module desf_dp #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [desf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [desf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [SAMPLE_BITS-1:0]            in_sample,
   input  wire logic                              in_restart,
   input  wire logic                              in_last,
   input  wire logic                              out_ready,
   output logic                                   out_valid,
   output logic [SAMPLE_BITS-1:0]                 out_forecast,
   output logic [desf_pkg::LEVEL_W-1:0]           out_single,
   output logic                                   out_final,
   input  wire desf_pkg::dp_cmd_type              cmd,
   output desf_pkg::dp_status_type                status
);

   localparam int ACC_W    = 52 + FRAC_BITS;
   localparam int BL_W     = ACC_W - 16;
   localparam int TR_SHIFT = 16 + FRAC_BITS;
   localparam int TR_W     = ACC_W - TR_SHIFT;
   localparam int LW       = desf_pkg::LEVEL_W;

   // configuration registers
   logic [desf_pkg::ALPHA_W-1:0] alpha_ff;
   logic [desf_pkg::BETA_W-1:0]  beta_ff;
   logic [desf_pkg::GAIN_W-1:0]  gain_ff;
   logic [LW-1:0]                init_ff;

   // series state
   logic [SAMPLE_BITS-1:0] prev_ff;
   logic [LW-1:0]          s1_ff;
   logic [LW-1:0]          s2_ff;
   logic                   started_ff;

   // current item
   logic [SAMPLE_BITS-1:0] x_ff;
   logic                   last_ff;
   logic                   start_ff;

   // arithmetic
   logic signed [desf_pkg::PROD_W-1:0]  prod_ff;
   logic signed [desf_pkg::PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]             acc_ff;
   logic signed [ACC_W-1:0]             acc_in;
   logic signed [ACC_W-1:0]             prod_ext;
   logic signed [ACC_W-1:0]             sum;
   logic signed [desf_pkg::MUL_A_W-1:0] mul_a;
   logic signed [desf_pkg::MUL_B_W-1:0] mul_b;
   logic [LW-1:0]                       single_ff;

   // output register
   logic                   valid_ff;
   logic [SAMPLE_BITS-1:0] fcast_out_ff;
   logic [LW-1:0]          single_out_ff;
   logic                   final_out_ff;

   logic [desf_pkg::ALPHA_W-1:0] alpha_eff;
   logic [desf_pkg::ALPHA_W-1:0] nalpha;
   logic [desf_pkg::ALPHA_W-1:0] nbeta;
   logic [SAMPLE_BITS-1:0]       prev_sel;
   logic [LW-1:0]                level_sel;
   logic signed [LW:0]           diff;
   logic signed [LW+2:0]         lead;
   logic [BL_W-1:0]              bl;
   logic [LW-1:0]                level;
   logic [TR_W-1:0]              tr;
   logic [SAMPLE_BITS-1:0]       fcast;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 17'd32768;
         beta_ff  <= 16'd32768;
         gain_ff  <= 24'd65536;
         init_ff  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            desf_pkg::CSR_ALPHA:         alpha_ff <= csr_wdata[desf_pkg::ALPHA_W-1:0];
            desf_pkg::CSR_BETA:          beta_ff  <= csr_wdata[desf_pkg::BETA_W-1:0];
            desf_pkg::CSR_TREND_GAIN:    gain_ff  <= csr_wdata[desf_pkg::GAIN_W-1:0];
            desf_pkg::CSR_INITIAL_LEVEL: init_ff  <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // factors, alpha above one acts as one
   assign alpha_eff = (alpha_ff > desf_pkg::ONE_Q16) ? desf_pkg::ONE_Q16 : alpha_ff;
   assign nalpha    = desf_pkg::ONE_Q16 - alpha_eff;
   assign nbeta     = desf_pkg::ONE_Q16 - {1'b0, beta_ff};

   // series start: sample is its own predecessor, level starts from the initial value
   assign prev_sel  = start_ff ? x_ff : prev_ff;
   assign level_sel = start_ff ? init_ff : s1_ff;

   // s1 - s2 and 2*s1 - s2
   assign diff = $signed({1'b0, s1_ff}) - $signed({1'b0, s2_ff});
   assign lead = $signed({2'b00, s1_ff, 1'b0}) - $signed({3'b000, s2_ff});

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         desf_pkg::MUL_ALPHA_PREV: begin
            mul_a = desf_pkg::MUL_A_W'(alpha_eff);
            mul_b = desf_pkg::MUL_B_W'(prev_sel);
         end
         desf_pkg::MUL_NALPHA_LEVEL: begin
            mul_a = desf_pkg::MUL_A_W'(nalpha);
            mul_b = desf_pkg::MUL_B_W'(level_sel);
         end
         desf_pkg::MUL_BETA_S1: begin
            mul_a = desf_pkg::MUL_A_W'(beta_ff);
            mul_b = desf_pkg::MUL_B_W'(s1_ff);
         end
         desf_pkg::MUL_NBETA_S2: begin
            mul_a = desf_pkg::MUL_A_W'(nbeta);
            mul_b = desf_pkg::MUL_B_W'(s2_ff);
         end
         desf_pkg::MUL_ALPHA_SAMPLE: begin
            mul_a = desf_pkg::MUL_A_W'(alpha_eff);
            mul_b = desf_pkg::MUL_B_W'(x_ff);
         end
         desf_pkg::MUL_NALPHA_S1: begin
            mul_a = desf_pkg::MUL_A_W'(nalpha);
            mul_b = desf_pkg::MUL_B_W'(s1_ff);
         end
         desf_pkg::MUL_GAIN_DIFF: begin
            mul_a = desf_pkg::MUL_A_W'(gain_ff);
            mul_b = {diff[LW], diff};
         end
         default: ;
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = ACC_W'(prod_ff);
   assign sum      = acc_ff + prod_ext;

   // accumulator load
   always_comb begin
      case (cmd.acc_op)
         desf_pkg::ACC_LOAD_SHIFT: acc_in = prod_ext <<< FRAC_BITS;
         desf_pkg::ACC_LOAD:       acc_in = prod_ext;
         desf_pkg::ACC_LOAD_TREND: acc_in = ACC_W'(lead) <<< 16;
         default:                  acc_in = acc_ff;
      endcase
   end

   // blend result, saturated at the level maximum
   assign bl    = sum[ACC_W-1:16];
   assign level = (|bl[BL_W-1:LW]) ? {LW{1'b1}} : bl[LW-1:0];

   // trend forecast: zero when negative, integer part saturated at the sample maximum
   assign tr = sum[ACC_W-1:TR_SHIFT];
   always_comb begin
      if (sum[ACC_W-1])
         fcast = '0;
      else if (|tr[TR_W-1:SAMPLE_BITS])
         fcast = {SAMPLE_BITS{1'b1}};
      else
         fcast = tr[SAMPLE_BITS-1:0];
   end

   // multiplier product and accumulator
   always_ff @(posedge clock) begin
      if (cmd.mul_op != desf_pkg::MUL_HOLD)
         prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff     <= in_sample;
         last_ff  <= in_last;
         start_ff <= in_restart | ~started_ff;
      end
   end

   // level write-back and series state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         s1_ff      <= '0;
         s2_ff      <= '0;
         started_ff <= 1'b0;
      end else begin
         case (cmd.wb_op)
            desf_pkg::WB_FIRST: begin
               s1_ff <= level;
               if (start_ff)
                  s2_ff <= level;
            end
            desf_pkg::WB_SECOND: s2_ff <= level;
            desf_pkg::WB_RESULT: begin
               prev_ff    <= x_ff;
               started_ff <= ~last_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wb_op == desf_pkg::WB_SINGLE)
         single_ff <= level;
   end

   // output register, freed by a transfer
   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (cmd.wb_op == desf_pkg::WB_RESULT)
         valid_ff <= 1'b1;
      else if (out_ready)
         valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.wb_op == desf_pkg::WB_RESULT) begin
         fcast_out_ff  <= fcast;
         single_out_ff <= single_ff;
         final_out_ff  <= last_ff;
      end
   end

   assign out_valid       = valid_ff;
   assign out_forecast    = fcast_out_ff;
   assign out_single      = single_out_ff;
   assign out_final       = final_out_ff;
   assign status.start    = start_ff;
   assign status.out_free = ~valid_ff | out_ready;

endmodule

`default_nettype wire

FILE: hw/rtl/desf_ctrl.sv
// desf_ctrl: sequencer of the forecaster, steps the shared multiplier through the blends
// issues datapath commands and takes its status
// depends on desf_pkg
`default_nettype none

module desf_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire desf_pkg::dp_status_type status,
   output desf_pkg::dp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_B1_M1,
      S_B1_M2,
      S_B1_W,
      S_B2_M1,
      S_B2_M2,
      S_B2_W,
      S_B3_M1,
      S_B3_M2,
      S_B3_W,
      S_TREND
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      ready_in   = ready_ff;
      cmd.capture = 1'b0;
      cmd.mul_op = desf_pkg::MUL_HOLD;
      cmd.acc_op = desf_pkg::ACC_HOLD;
      cmd.wb_op  = desf_pkg::WB_NONE;
      case (state_ff)
         S_IDLE: begin
            if (in_valid && ready_ff) begin
               cmd.capture = 1'b1;
               ready_in    = 1'b0;
               state_in    = S_B1_M1;
            end
         end
         // first level: alpha blend of previous sample with old level
         S_B1_M1: begin
            cmd.mul_op = desf_pkg::MUL_ALPHA_PREV;
            state_in   = S_B1_M2;
         end
         S_B1_M2: begin
            cmd.mul_op = desf_pkg::MUL_NALPHA_LEVEL;
            cmd.acc_op = desf_pkg::ACC_LOAD_SHIFT;
            state_in   = S_B1_W;
         end
         S_B1_W: begin
            cmd.wb_op = desf_pkg::WB_FIRST;
            state_in  = status.start ? S_B3_M1 : S_B2_M1;
         end
         // second level: beta blend of the two levels
         S_B2_M1: begin
            cmd.mul_op = desf_pkg::MUL_BETA_S1;
            state_in   = S_B2_M2;
         end
         S_B2_M2: begin
            cmd.mul_op = desf_pkg::MUL_NBETA_S2;
            cmd.acc_op = desf_pkg::ACC_LOAD;
            state_in   = S_B2_W;
         end
         S_B2_W: begin
            cmd.wb_op = desf_pkg::WB_SECOND;
            state_in  = S_B3_M1;
         end
         // single forecast: alpha blend of current sample with new level
         S_B3_M1: begin
            cmd.mul_op = desf_pkg::MUL_ALPHA_SAMPLE;
            state_in   = S_B3_M2;
         end
         S_B3_M2: begin
            cmd.mul_op = desf_pkg::MUL_NALPHA_S1;
            cmd.acc_op = desf_pkg::ACC_LOAD_SHIFT;
            state_in   = S_B3_W;
         end
         S_B3_W: begin
            cmd.wb_op  = desf_pkg::WB_SINGLE;
            cmd.mul_op = desf_pkg::MUL_GAIN_DIFF;
            cmd.acc_op = desf_pkg::ACC_LOAD_TREND;
            state_in   = S_TREND;
         end
         // trend forecast, waits for a free output register
         S_TREND: begin
            if (status.out_free) begin
               cmd.wb_op = desf_pkg::WB_RESULT;
               ready_in  = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            ready_in = 1'b1;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign in_ready = ready_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/double_exponential_smoothing_forecast.sv
// double exponential smoothing forecaster, one result per sample, one shared multiplier
// each sample goes through the first-level blend, the second-level blend (skipped when a
// series starts), the single forecast and the trend forecast; a new sample is taken only
// once the result is written; its seven products (five at a series start) are each accumulated
// reset: synchronous active high, clears levels, previous sample and series flag, and loads
// alpha = beta = 0.5, trend gain = 1.0, initial level = 0
// depends on desf_pkg, desf_ctrl and desf_dp
`default_nettype none

module double_exponential_smoothing_forecast #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // configuration writes
   input  wire logic                                      csr_we,
   input  wire logic [desf_pkg::CSR_ADDR_W-1:0]           csr_addr,
   input  wire logic [desf_pkg::CSR_DATA_W-1:0]           csr_wdata,
   // sample stream
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]          req_tdata,  // sample
   input  wire logic                                      req_tuser,  // restart_series
   input  wire logic                                      req_tlast,  // last_sample
   // forecast stream
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   output logic [((SAMPLE_BITS+desf_pkg::LEVEL_W+7)/8)*8-1:0] rsp_tdata, // forecast, single_forecast
   output logic                                           rsp_tlast   // is_final
);

   localparam int OUT_DATA_W = ((SAMPLE_BITS + desf_pkg::LEVEL_W + 7) / 8) * 8;

   desf_pkg::dp_cmd_type    cmd;
   desf_pkg::dp_status_type status;

   logic [SAMPLE_BITS-1:0]         forecast;
   logic [desf_pkg::LEVEL_W-1:0]   single_forecast;

   desf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   desf_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .in_sample    (req_tdata[SAMPLE_BITS-1:0]),
      .in_restart   (req_tuser),
      .in_last      (req_tlast),
      .out_ready    (rsp_tready),
      .out_valid    (rsp_tvalid),
      .out_forecast (forecast),
      .out_single   (single_forecast),
      .out_final    (rsp_tlast),
      .cmd          (cmd),
      .status       (status)
   );

   // pack result, zero fill to whole bytes
   assign rsp_tdata = OUT_DATA_W'({single_forecast, forecast});

endmodule

`default_nettype wire
